@@ hdl/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants for the 3x3 ring pattern counter.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int CFG_W     = 11;  // width of a configuration register
    localparam int CFG_IDX_W = 1;   // width of the register index
    localparam int COUNT_W   = 20;  // width of the result count

    localparam logic [CFG_W-1:0]   DIM_RESET     = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    // centre open, all eight neighbours wall
    localparam logic [8:0]         RING_TEMPLATE = 9'h1EF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // one line store entry: the pixel two rows up and the pixel one row up
    typedef struct packed {
        logic upper;
        logic middle;
    } line_pair_t;

    // 3x3 window: bits 2:0 top row, 5:3 middle row, 8:6 bottom row,
    // lowest bit of each row the oldest column
    typedef logic [8:0] window_t;

endpackage

@@ hdl/ring_pattern_counter_3x3.sv @@
// ----------------------------------------------------------------------------
// ring_pattern_counter_3x3: counts 3x3 ring templates in a raster pixel stream
// Result: a frame's last pixel is registered in stage A, then its count loads m_*.
// Throughput: one pixel per cycle, set by the line store's one read and one write
//   a cycle; the last pixel of a frame waits while an earlier result is untaken.
// Reset: synchronous, active low; counters, window and handshakes clear, no input.
// ----------------------------------------------------------------------------

// Structure
//   Accept:   a pixel is taken while stage A is empty or moving on. At the same
//             edge the line store is read at the pixel's column and the column
//             and row counters advance against the configured geometry.
//   Stage A:  the pixel, its read-back line pair, and the in-frame and
//             end-of-frame flags. Shift the window, compare it with the ring
//             template, update the saturating match count, and write the
//             line pair back (middle moves to upper, the pixel to middle).
//   Output:   one result register, loaded on the last pixel of a frame.
//
// The line store is read-first. When the item leaving stage A writes the
// very address the incoming item reads (a one-pixel-wide image), the
// written pair is forwarded in place of the stale read data.
// Line store entries are never cleared: the first two rows of each frame
// fill them, and no window is counted before row 2 and column 2.
module ring_pattern_counter_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]       cfg_data,

    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_wall_pixel,

    // frame result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rpc_pkg::COUNT_W-1:0]     m_ring_count
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LINE_W = $bits(rpc_pkg::line_pair_t);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rpc_pkg::CFG_W-1:0] width_reg;
    logic [rpc_pkg::CFG_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rpc_pkg::DIM_RESET;
            height_reg <= rpc_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            case (rpc_pkg::cfg_reg_t'(cfg_index))
                rpc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                rpc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last column and row index: zero acts as one, above the maximum
    // acts as the maximum.
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb begin
        if (width_reg == '0) begin
            col_last = '0;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            col_last = COL_W'(32'(width_reg) - 1);
        end

        if (height_reg == '0) begin
            row_last = '0;
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            row_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            row_last = ROW_W'(32'(height_reg) - 1);
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic a_last_reg;
    logic out_valid_reg;
    logic a_adv;
    logic s_fire;

    // Stage A only waits when it would produce a result and the output
    // register still holds one that has not been taken. Take nothing
    // while reset is held.
    assign a_adv   = a_valid_reg && !(a_last_reg && out_valid_reg && !m_ready);
    assign s_ready = aresetn && (!a_valid_reg || a_adv);
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Column and row counters, advanced on accept
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_wrap;
    logic             row_wrap;

    assign col_wrap = (col_reg >= col_last);
    assign row_wrap = (row_reg >= row_last);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A register
    // ------------------------------------------------------------------
    logic             a_pixel_reg;
    logic             a_gate_reg;
    logic [COL_W-1:0] a_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= 1'b1;
            a_last_reg  <= col_wrap && row_wrap;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    // payload: hold while stage A stalls
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_pixel_reg <= s_wall_pixel;
            a_addr_reg  <= col_reg;
            a_gate_reg  <= (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
        end
    end

    // ------------------------------------------------------------------
    // Line store with write-to-read forwarding
    // ------------------------------------------------------------------
    rpc_pkg::line_pair_t line_rd;
    rpc_pkg::line_pair_t line_wr;
    rpc_pkg::line_pair_t line_cur;
    rpc_pkg::line_pair_t fwd_data_reg;
    logic                fwd_hit_reg;

    assign line_wr.upper  = line_cur.middle;
    assign line_wr.middle = a_pixel_reg;

    rpc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (a_adv),
        .wr_addr (a_addr_reg),
        .wr_data (line_wr),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_hit_reg <= a_adv && (a_addr_reg == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_data_reg <= line_wr;
        end
    end

    assign line_cur = fwd_hit_reg ? fwd_data_reg : line_rd;

    // ------------------------------------------------------------------
    // Window, template match and saturating count
    // ------------------------------------------------------------------
    rpc_pkg::window_t             win_reg, win_next, win_shift;
    logic [rpc_pkg::COUNT_W-1:0]  total_reg, total_next, total_upd;
    logic                         hit;

    always_comb begin
        // shift each row by one column, newest pixel on the high bit
        win_shift[2:0] = {line_cur.upper,  win_reg[2:1]};
        win_shift[5:3] = {line_cur.middle, win_reg[5:4]};
        win_shift[8:6] = {a_pixel_reg,     win_reg[8:7]};

        hit       = a_gate_reg && (win_shift == rpc_pkg::RING_TEMPLATE);
        total_upd = (hit && (total_reg != rpc_pkg::COUNT_MAX))
                    ? total_reg + rpc_pkg::COUNT_W'(1) : total_reg;

        win_next   = win_reg;
        total_next = total_reg;
        if (a_adv) begin
            // clear for the next frame after its last pixel
            win_next   = a_last_reg ? '0 : win_shift;
            total_next = a_last_reg ? '0 : total_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            total_reg <= '0;
        end else begin
            win_reg   <= win_next;
            total_reg <= total_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [rpc_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (a_adv && a_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_last_reg) begin
            count_reg <= total_upd;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_ring_count = count_reg;

endmodule

@@ hdl/rpc_ram.sv @@
// ----------------------------------------------------------------------------
// rpc_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module rpc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/rpc_checker.sv @@
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level assertions for the ring pattern counter, bound to its top level.
// ----------------------------------------------------------------------------
module rpc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rpc_pkg::COUNT_W-1:0] m_ring_count
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ring_count))
        else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result follows an accepted pixel through stage A and the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a preceding pixel");

    // with the result register empty the input never stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

endmodule

bind ring_pattern_counter_3x3 rpc_checker u_rpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ring_count (m_ring_count)
);

@@ tb/sv/ring_count_checker.sv @@
// ----------------------------------------------------------------------------
// ring_count_checker
// Watches the pixel, result and configuration ports of the ring pattern
// counter, predicts the count of every frame and compares each result.
// ----------------------------------------------------------------------------
module ring_count_checker
    import rpc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_wall_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [COUNT_W-1:0]   m_ring_count,
    output int                   mismatch_count,
    output int                   counts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);

    // mirror of the block's frame state
    logic               upper_row  [MAX_WIDTH];
    logic               middle_row [MAX_WIDTH];
    window_t            window;
    logic [COL_W-1:0]   col_idx;
    logic [ROW_W-1:0]   row_idx;
    logic [COUNT_W-1:0] ring_total;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    logic [COUNT_W-1:0] expected_counts [$];
    logic [COUNT_W-1:0] wanted_count;

    initial begin
        mismatch_count = 0;
        counts_pending = 0;
    end

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int effective_dim(input logic [CFG_W-1:0] value, input int limit);
        if (value == '0) return 1;
        if (int'(value) > limit) return limit;
        return int'(value);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // shift one pixel into the window and line stores, count, close the frame
    task automatic take_pixel(input logic pix);
        int   cols;
        int   rows;
        logic up;
        logic md;
        cols = effective_dim(width_reg, MAX_WIDTH);
        rows = effective_dim(height_reg, MAX_HEIGHT);
        up = upper_row[col_idx];
        md = middle_row[col_idx];
        upper_row[col_idx]  = md;
        middle_row[col_idx] = pix;
        window = {pix, window[8:7], md, window[5:4], up, window[2:1]};
        if (col_idx >= 2 && row_idx >= 2 && window == RING_TEMPLATE
                && ring_total != COUNT_MAX)
            ring_total++;
        if (int'(col_idx) >= cols - 1) begin
            col_idx = '0;
            if (int'(row_idx) >= rows - 1) begin
                expected_counts.push_back(ring_total);
                row_idx    = '0;
                ring_total = '0;
                window     = '0;
            end else begin
                row_idx++;
            end
        end else begin
            col_idx++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (upper_row[i]) begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            window     = '0;
            col_idx    = '0;
            row_idx    = '0;
            ring_total = '0;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            expected_counts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a result never stems from this edge's pixel
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    note_failure($sformatf("unexpected ring_count %0d, none pending",
                                           m_ring_count));
                end else begin
                    wanted_count = expected_counts.pop_front();
                    if (m_ring_count !== wanted_count)
                        note_failure($sformatf("ring_count: expected %0d, got %0d",
                                               wanted_count, m_ring_count));
                end
            end
            if (s_valid && s_ready) take_pixel(s_wall_pixel);
        end
        counts_pending = expected_counts.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3x3 ring pattern counter: directed frames,
// a back-pressure phase, random frames of small size and one frame of the
// largest width, checked by ring_count_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import rpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int RANDOM_ITEMS   = 860;    // minimum pixel count of the random part
    localparam int IDLE_MAX       = 19;     // longest gap either side draws
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int PRESSURE_ITEMS = 40;     // one-pixel frames pushed into the hold-off
    localparam int SETTLE_CYCLES  = 8;      // settling wait after the last result arrives
    // Longest correct stretch with no item moving is the hold-off plus one
    // gap on each side and the latency; the limit is many times that.
    localparam int STALL_LIMIT    = 5000;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    cfg_reg_t           cfg_index    = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   cfg_data     = '0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic               s_wall_pixel = 1'b0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [COUNT_W-1:0] m_ring_count;

    int mismatch_count;
    int counts_pending;
    int pixels_sent   = 0;
    int stall_cycles  = 0;
    bit idle_on       = 1'b1;   // both sides draw random gaps while set
    bit hold_request  = 1'b0;   // asks the receiver for one long hold-off

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ring_pattern_counter_3x3 #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_wall_pixel (s_wall_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ring_count (m_ring_count)
    );

    ring_count_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_wall_pixel   (s_wall_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ring_count   (m_ring_count),
        .mismatch_count (mismatch_count),
        .counts_pending (counts_pending)
    );

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: draw a gap per result, hold m_ready low for it, then wait
    // for the result. Serve one long hold-off when asked, counted here.
    initial begin
        int gap;
        bit hold_served;
        hold_served = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Offer one pixel after a drawn gap; return at the edge that takes it.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_pixel(input logic pix);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_wall_pixel <= pix;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pixels_sent++;
    endtask

    // Drop valid and pause until every expected count has arrived, then
    // let the pipeline settle so the block is idle for a register write.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (counts_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write width then height as back-to-back register writes.
    task automatic set_geometry(input logic [CFG_W-1:0] cols_reg,
                                input logic [CFG_W-1:0] rows_reg);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= cols_reg;
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= rows_reg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One geometry, a run of pixels with walls dominant: a pixel is open
    // with odds of one in open_odds, so rings appear at the sparse settings.
    task automatic run_frames(input logic [CFG_W-1:0] cols_reg,
                              input logic [CFG_W-1:0] rows_reg,
                              input int pixel_total, input int open_odds);
        set_geometry(cols_reg, rows_reg);
        for (int i = 0; i < pixel_total; i++)
            send_pixel($urandom_range(0, open_odds - 1) != 0);
        drain_results();
    endtask

    // Mostly tiny dimensions, now and then a wider one.
    function automatic int pick_dim();
        if ($urandom_range(0, 15) == 0) return $urandom_range(13, 48);
        return $urandom_range(1, 12);
    endfunction

    initial begin
        int               cols;
        int               rows;
        int               open_odds;
        int               random_start;
        logic [CFG_W-1:0] cols_reg;
        logic [CFG_W-1:0] rows_reg;

        // hold reset at the start, once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one exact ring in a 3x3 frame
        set_geometry(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) send_pixel(RING_TEMPLATE[i]);
        drain_results();
        // zero register acts as one: a single-pixel frame counts nothing
        set_geometry('0, 11'd1);
        send_pixel(1'b0);
        drain_results();
        // frames too narrow or too short for any window
        run_frames(11'd2, 11'd4, 8, 6);
        run_frames(11'd4, 11'd2, 8, 6);

        // Pressure: one-pixel frames, no gaps at the sender, while the
        // receiver holds off long enough for the block to stall its input.
        idle_on      = 1'b0;
        hold_request = 1'b1;
        run_frames(11'd1, 11'd1, PRESSURE_ITEMS, 2);
        hold_request = 1'b0;

        // Random frames: small geometries, rings planted by sparse openings,
        // some noisy frames, gaps on most frames and none on the rest.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            cols = pick_dim();
            rows = pick_dim();
            case ($urandom_range(0, 3))
                0:       open_odds = 2;
                1:       open_odds = 16;
                default: open_odds = 6;
            endcase
            idle_on  = $urandom_range(0, 3) != 0;
            cols_reg = (cols == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(cols);
            rows_reg = (rows == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(rows);
            run_frames(cols_reg, rows_reg, cols * rows, open_odds);
        end

        // Largest width: a register past the maximum acts as the maximum.
        // Keep the frame to a single row so the run stays short.
        idle_on = 1'b1;
        run_frames('1, 11'd1, MAX_WIDTH, 6);

        if (mismatch_count == 0 && counts_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rpc_pkg.sv
hdl/rpc_ram.sv
hdl/ring_pattern_counter_3x3.sv
hdl/rpc_checker.sv
tb/sv/ring_count_checker.sv
tb/sv/tb_top.sv
